// ===== rtl/u8akd_pkg.sv =====
package u8akd_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [2:0]  key_kind;
      logic [15:0] char_code;
   } rsp_type;

   // key kinds
   localparam logic [2:0] KIND_CHAR   = 3'd0;
   localparam logic [2:0] KIND_UP     = 3'd1;
   localparam logic [2:0] KIND_DOWN   = 3'd2;
   localparam logic [2:0] KIND_RIGHT  = 3'd3;
   localparam logic [2:0] KIND_LEFT   = 3'd4;
   localparam logic [2:0] KIND_DELETE = 3'd5;
   localparam logic [2:0] KIND_END    = 3'd6;

   // byte codes
   localparam logic [7:0] ASCII_ESC    = 8'h1B;
   localparam logic [7:0] ASCII_LBRACK = 8'h5B;
   localparam logic [7:0] ASCII_UPPER_O = 8'h4F;
   localparam logic [7:0] ASCII_UPPER_A = 8'h41;
   localparam logic [7:0] ASCII_UPPER_B = 8'h42;
   localparam logic [7:0] ASCII_UPPER_C = 8'h43;
   localparam logic [7:0] ASCII_UPPER_D = 8'h44;
   localparam logic [7:0] ASCII_TILDE  = 8'h7E;
   localparam logic [7:0] ASCII_ZERO   = 8'h30;
   localparam logic [7:0] ASCII_NINE   = 8'h39;

   // decoded code points and CSI parameter values of interest
   localparam logic [15:0] CODE_CSI       = 16'h009B;
   localparam logic [15:0] CODE_PRINT_MIN = 16'h00A0;
   localparam logic [15:0] CODE_OVERLONG  = 16'h0020;
   localparam logic [15:0] PARAM_DELETE   = 16'd3;
   localparam logic [15:0] PARAM_MAX      = 16'hFFFF;

endpackage

// ===== rtl/utf8_ansi_key_decoder.sv =====
// channel | direction | payload                         | handshake
// req     | in        | u8akd_pkg::req_type (byte, eoi) | req_valid / req_ready
// rsp     | out       | u8akd_pkg::rsp_type (kind, code)| rsp_valid / rsp_ready
//
// one byte per cycle while no key waits in the result register; a byte is held in
// the input register and its key (if any) is then registered in the result register
// synchronous active-high reset clears parser state and both valid flags
// a byte that makes no key never waits; a byte that makes a key waits in the
// input register while an untaken key sits in the result register, and
// req_ready stays low until that key is taken
module utf8_ansi_key_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  u8akd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output u8akd_pkg::rsp_type rsp_data
);

   localparam logic [1:0] MODE_BARE = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_CSI  = 2'd2;

   // input register
   logic               in_valid_ff, in_valid_in;
   u8akd_pkg::req_type in_ff, in_in;

   // parser state
   logic [1:0]  mode_ff, mode_in;
   logic [1:0]  pend_ff, pend_in;
   logic [15:0] accum_ff, accum_in;
   logic [15:0] param_ff, param_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   u8akd_pkg::rsp_type out_ff, out_in;

   logic        emit_key;
   logic [2:0]  key_kind;
   logic [15:0] key_code;
   logic [7:0]  cur_byte;
   logic [1:0]  pend_dec;
   logic [15:0] shifted;
   logic [19:0] param_mul;
   logic        advance;

   assign cur_byte  = in_ff.in_byte;
   assign pend_dec  = pend_ff - 2'd1;
   assign shifted   = {accum_ff[9:0], cur_byte[5:0]};
   assign param_mul = {1'b0, param_ff, 3'b000} + {3'b000, param_ff, 1'b0}
                    + {16'd0, cur_byte[3:0]};

   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      accum_in = accum_ff;
      param_in = param_ff;
      emit_key = 1'b0;
      key_kind = u8akd_pkg::KIND_CHAR;
      key_code = 16'd0;
      if (in_ff.end_of_input) begin
         emit_key = 1'b1;
         key_kind = u8akd_pkg::KIND_END;
      end else if (cur_byte[7:4] == 4'hE) begin
         accum_in = {12'd0, cur_byte[3:0]};
         pend_in  = 2'd2;
      end else if (cur_byte[7:5] == 3'b110) begin
         accum_in = {11'd0, cur_byte[4:0]};
         pend_in  = 2'd1;
      end else if (cur_byte[7]) begin
         if (pend_ff != 2'd0) begin
            accum_in = shifted;
            pend_in  = pend_dec;
            if (pend_dec == 2'd1 && shifted < u8akd_pkg::CODE_OVERLONG) begin
               // overlong three-byte form, drop the sequence
               pend_in  = 2'd0;
               accum_in = 16'd0;
               mode_in  = MODE_BARE;
            end else if (pend_dec == 2'd0) begin
               mode_in = MODE_BARE;
               if (shifted == u8akd_pkg::CODE_CSI) begin
                  mode_in = MODE_CSI;
               end else if (shifted >= u8akd_pkg::CODE_PRINT_MIN) begin
                  emit_key = 1'b1;
                  key_code = shifted;
               end
            end
         end
      end else if (cur_byte == u8akd_pkg::ASCII_ESC) begin
         mode_in = MODE_ESC;
      end else if (mode_ff == MODE_ESC && (cur_byte == u8akd_pkg::ASCII_LBRACK ||
                                           cur_byte == u8akd_pkg::ASCII_UPPER_O)) begin
         mode_in = MODE_CSI;
      end else if (mode_ff == MODE_CSI) begin
         if (cur_byte >= u8akd_pkg::ASCII_ZERO && cur_byte <= u8akd_pkg::ASCII_NINE) begin
            param_in = (param_mul[19:16] != 4'd0) ? u8akd_pkg::PARAM_MAX
                                                  : param_mul[15:0];
         end else begin
            mode_in = MODE_BARE;
            unique case (cur_byte)
               u8akd_pkg::ASCII_UPPER_A: begin
                  emit_key = 1'b1;
                  key_kind = u8akd_pkg::KIND_UP;
               end
               u8akd_pkg::ASCII_UPPER_B: begin
                  emit_key = 1'b1;
                  key_kind = u8akd_pkg::KIND_DOWN;
               end
               u8akd_pkg::ASCII_UPPER_C: begin
                  emit_key = 1'b1;
                  key_kind = u8akd_pkg::KIND_RIGHT;
               end
               u8akd_pkg::ASCII_UPPER_D: begin
                  emit_key = 1'b1;
                  key_kind = u8akd_pkg::KIND_LEFT;
               end
               u8akd_pkg::ASCII_TILDE: begin
                  if (param_ff == u8akd_pkg::PARAM_DELETE) begin
                     emit_key = 1'b1;
                     key_kind = u8akd_pkg::KIND_DELETE;
                  end
               end
               default: begin
                  emit_key = 1'b0;
               end
            endcase
         end
      end else begin
         emit_key = 1'b1;
         key_code = {8'd0, cur_byte};
      end
      if (emit_key) begin
         mode_in  = MODE_BARE;
         pend_in  = 2'd0;
         accum_in = 16'd0;
         param_in = 16'd0;
      end
   end

   // a byte that makes no key never waits for the result register
   assign advance   = in_valid_ff && (!emit_key || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_in        = in_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         if (emit_key) begin
            out_valid_in     = 1'b1;
            out_in.key_kind  = key_kind;
            out_in.char_code = key_code;
         end
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in       = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_BARE;
         pend_ff      <= 2'd0;
         accum_ff     <= 16'd0;
         param_ff     <= 16'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            mode_ff  <= mode_in;
            pend_ff  <= pend_in;
            accum_ff <= accum_in;
            param_ff <= param_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   a_clear_after_key: assert property (@(posedge clock) disable iff (reset)
      (advance && emit_key) |=> (mode_ff == MODE_BARE && pend_ff == 2'd0 &&
                                 accum_ff == 16'd0 && param_ff == 16'd0))
      else $error("parser state not cleared after a key");

   a_code_only_for_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.key_kind != u8akd_pkg::KIND_CHAR) |->
         (rsp_data.char_code == 16'd0))
      else $error("non-character key carries a code");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_ff)))
      else $error("stalled input register lost its byte");

   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      (pend_ff != 2'd3))
      else $error("continuation count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("waiting key overwritten");
`endif

endmodule
